FILE: rtl/largest_smaller_on_right_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the largest-smaller-on-right block
// Shared assertion forms, checked on the rising edge of i_clk while out of reset.
// ----------------------------------------------------------------------------
`ifndef LARGEST_SMALLER_ON_RIGHT_MACROS_SVH
`define LARGEST_SMALLER_ON_RIGHT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/lsr_pkg.sv
// ----------------------------------------------------------------------------
// lsr_pkg
// Sizes and the token type that travels along the chain of search cells.
// ----------------------------------------------------------------------------
package lsr_pkg;

    // Number of cells in the store.
    localparam int CAPACITY    = 256;
    // Width of one signed element.
    localparam int VALUE_WIDTH = 32;

    // One word in flight through the chain, with its running search result.
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] value;
        logic                          start;
        logic                          placed;
        logic                          found;
        logic signed [VALUE_WIDTH-1:0] best;
    } t_token;

endpackage

FILE: rtl/lsr_if.sv
// ----------------------------------------------------------------------------
// lsr_if
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------

// Input channel: one array element per word.
interface lsr_in_if import lsr_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          start_new;

    modport source (output valid, output value, output start_new, input ready);
    modport sink   (input valid, input value, input start_new, output ready);
endinterface

// Result channel: one answer per input word.
interface lsr_out_if import lsr_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic                          found;
    logic signed [VALUE_WIDTH-1:0] predecessor;
    logic                          store_full;

    modport source (output valid, output found, output predecessor, output store_full,
                    input ready);
    modport sink   (input valid, input found, input predecessor, input store_full,
                    output ready);
endinterface

FILE: rtl/lsr_cell.sv
// ----------------------------------------------------------------------------
// lsr_cell
// One storage cell of the chain: holds a value, takes the word passing by
// when it is free, and folds its value into the word's running search.
// ----------------------------------------------------------------------------
`include "largest_smaller_on_right_macros.svh"

module lsr_cell import lsr_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_advance,
    input  logic   i_tok_valid,
    input  t_token i_tok,
    output logic   o_tok_valid,
    output t_token o_tok
);

    logic                          r_cell_valid;
    logic signed [VALUE_WIDTH-1:0] r_cell_value;
    logic                          r_tok_valid;
    t_token                        r_tok;

    logic   eff_valid;
    logic   take;
    logic   is_less;
    logic   n_cell_valid;
    t_token n_tok;

    // A start word empties the cell before it is looked at.
    assign eff_valid    = r_cell_valid && !i_tok.start;
    assign take         = !eff_valid && !i_tok.placed;
    assign is_less      = eff_valid && (r_cell_value < i_tok.value);
    assign n_cell_valid = eff_valid || take;

    // Update the word's placement and its best smaller value so far.
    always_comb begin
        n_tok = i_tok;
        if (take) begin
            n_tok.placed = 1'b1;
        end
        if (is_less && (!i_tok.found || (r_cell_value > i_tok.best))) begin
            n_tok.found = 1'b1;
            n_tok.best  = r_cell_value;
        end
    end

    // Control state: occupancy and word valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_valid <= 1'b0;
            r_tok_valid  <= 1'b0;
        end else if (i_advance) begin
            r_tok_valid <= i_tok_valid;
            if (i_tok_valid) begin
                r_cell_valid <= n_cell_valid;
            end
        end
    end

    // Payload: stored value and the word handed to the next cell.
    always_ff @(posedge i_clk) begin
        if (i_advance && i_tok_valid) begin
            r_tok <= n_tok;
            if (take) begin
                r_cell_value <= i_tok.value;
            end
        end
    end

    assign o_tok_valid = r_tok_valid;
    assign o_tok       = r_tok;

    // A free cell always captures a word that has not been placed yet.
    `LSR_ASSERT_NEXT(a_take_free, i_advance && i_tok_valid && take, r_cell_valid && r_tok.placed && (r_cell_value == r_tok.value), "free cell did not capture word")
    // A found answer is strictly below the word's value.
    `LSR_ASSERT_NOW(a_best_below, r_tok_valid && r_tok.found, r_tok.best < r_tok.value, "best is not below value")
    // Without an answer the best value stays zero.
    `LSR_ASSERT_NOW(a_best_zero, r_tok_valid && !r_tok.found, r_tok.best == '0, "best not zero without answer")

endmodule

FILE: rtl/largest_smaller_on_right.sv
// ----------------------------------------------------------------------------
// largest_smaller_on_right
// Streaming largest-smaller-element-on-right over a chain of storage cells.
// ----------------------------------------------------------------------------
// Feed an array's elements from the last to the first; set start_new on the
// first word of each array to empty the store. Each word runs down a chain of
// CAPACITY cells, one cell per cycle: the first free cell keeps the value,
// and every occupied cell offers its value to the word's running search for
// the greatest stored value strictly below it. A result word is presented
// from the last cell's register, and since words follow one another cell
// by cell, one word is accepted per cycle while the result side is ready.
// A stall on the result side halts the whole chain. When all cells are
// occupied the value is not kept and store_full is set; found is 0 and
// predecessor is 0 when no stored value is smaller.
// ----------------------------------------------------------------------------
module largest_smaller_on_right import lsr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lsr_in_if.sink    i_in,
    lsr_out_if.source o_out
);

    logic   w_vld [CAPACITY+1];
    t_token w_tok [CAPACITY+1];
    logic   advance;

    // The chain moves whenever the last cell's result is free or being taken.
    // No word is taken while reset is held.
    assign advance    = !w_vld[CAPACITY] || o_out.ready;
    assign i_in.ready = advance && i_rst_n;

    // Word entering the first cell.
    assign w_vld[0]        = i_in.valid;
    assign w_tok[0].value  = i_in.value;
    assign w_tok[0].start  = i_in.start_new;
    assign w_tok[0].placed = 1'b0;
    assign w_tok[0].found  = 1'b0;
    assign w_tok[0].best   = '0;

    // Row of cells.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        lsr_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_advance   (advance),
            .i_tok_valid (w_vld[g]),
            .i_tok       (w_tok[g]),
            .o_tok_valid (w_vld[g+1]),
            .o_tok       (w_tok[g+1])
        );
    end

    // The last cell's register is the result register.
    assign o_out.valid       = w_vld[CAPACITY];
    assign o_out.found       = w_tok[CAPACITY].found;
    assign o_out.predecessor = w_tok[CAPACITY].best;
    assign o_out.store_full  = !w_tok[CAPACITY].placed;

endmodule

FILE: sim/largest_smaller_on_right_tb.sv
// ----------------------------------------------------------------------------
// largest_smaller_on_right_tb
// Self-checking bench for the largest-smaller-on-right search chain.
// ----------------------------------------------------------------------------
// Arrays of signed words go in with start_new on their first word. A
// scoreboard keeps its own copy of the store, predicts found, predecessor
// and store_full for every accepted word, and checks each result word in
// order. Stimulus is a short directed list followed by random arrays. Most
// arrays are short, and a few run past the store capacity. Both sides idle
// at random. Once, the result side holds off long enough to back up the chain.
// ----------------------------------------------------------------------------
import lsr_pkg::*;

// One predicted result word.
typedef struct {
    logic                          found;
    logic signed [VALUE_WIDTH-1:0] predecessor;
    logic                          store_full;
} t_answer;

// Predicts the answers from a private copy of the store and checks results.
class lsr_scoreboard;
    logic signed [VALUE_WIDTH-1:0] stored[$];
    t_answer                       answers_due[$];
    int                            fails;
    int                            checked;
    int                            full_hits;
    int                            found_hits;
    int                            arrays;

    function new();
        fails      = 0;
        checked    = 0;
        full_hits  = 0;
        found_hits = 0;
        arrays     = 0;
    endfunction

    function int pending();
        return answers_due.size();
    endfunction

    // Update the store with an accepted word and queue its answer.
    function void note_word(logic signed [VALUE_WIDTH-1:0] value, logic start);
        t_answer ans;
        if (start) begin
            stored.delete();
            arrays++;
        end
        ans.found       = 1'b0;
        ans.predecessor = '0;
        ans.store_full  = (stored.size() >= CAPACITY);
        if (!ans.store_full) begin
            stored.insert(stored.size(), value);
        end
        // Greatest stored value strictly below the word; equal values never win.
        foreach (stored[i]) begin
            if (stored[i] < value && (!ans.found || stored[i] > ans.predecessor)) begin
                ans.predecessor = stored[i];
                ans.found       = 1'b1;
            end
        end
        answers_due.insert(answers_due.size(), ans);
    endfunction

    task report(string what);
        fails++;
        if (fails <= 20) begin
            $display("mismatch %0d: %s", fails, what);
        end
    endtask

    // Compare one result word with the oldest predicted answer.
    task check_answer(logic found, logic signed [VALUE_WIDTH-1:0] predecessor,
                      logic store_full);
        t_answer want;
        if (answers_due.size() == 0) begin
            report("result word with no answer pending");
        end else begin
            want = answers_due.pop_front();
            checked++;
            if (want.store_full) full_hits++;
            if (want.found) found_hits++;
            if (found !== want.found) begin
                report($sformatf("word %0d found got %b want %b", checked, found,
                                 want.found));
            end
            if (predecessor !== want.predecessor) begin
                report($sformatf("word %0d predecessor got %0d want %0d", checked,
                                 predecessor, want.predecessor));
            end
            if (store_full !== want.store_full) begin
                report($sformatf("word %0d store_full got %b want %b", checked,
                                 store_full, want.store_full));
            end
        end
    endtask
endclass

module largest_smaller_on_right_tb;

    localparam int WORD_TARGET = 1850;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_OFF    = 700;
    localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
    localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

    typedef enum int {SPREAD_NARROW, SPREAD_WIDE, SPREAD_EDGES} t_spread;

    logic i_clk;
    logic i_rst_n;
    bit   out_of_reset;
    bit   quiet_phase;
    int   cycles;
    int   words_sent;

    lsr_scoreboard sb;

    lsr_in_if  in_ch ();
    lsr_out_if out_ch ();

    largest_smaller_on_right DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Gap length: mostly none or short, now and then long.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_phase || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function logic signed [VALUE_WIDTH-1:0] pick_value(t_spread spread);
        logic signed [VALUE_WIDTH-1:0] v;
        v = VALUE_WIDTH'($urandom());
        case (spread)
            SPREAD_NARROW: begin
                v = $signed($urandom_range(0, 16)) - 8;
            end
            SPREAD_EDGES: begin
                case ($urandom_range(0, 7))
                    0: v = VMIN;
                    1: v = VMIN + 1;
                    2: v = -1;
                    3: v = 0;
                    4: v = 1;
                    5: v = VMAX - 1;
                    6: v = VMAX;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return v;
    endfunction

    // Offer one word and hold it until the chain takes it.
    task send_word(logic signed [VALUE_WIDTH-1:0] value, logic start);
        @(negedge i_clk);
        in_ch.valid     = 1'b1;
        in_ch.value     = value;
        in_ch.start_new = start;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_word(value, start);
        words_sent++;
    endtask

    // Idle the input with junk on the payload.
    task idle_input(int n);
        repeat (n) begin
            @(negedge i_clk);
            in_ch.valid     = 1'b0;
            in_ch.value     = VALUE_WIDTH'($urandom());
            in_ch.start_new = 1'($urandom_range(0, 1));
        end
    endtask

    // One array: start_new on its first word, then idle gaps between words.
    task send_array(int length, t_spread spread);
        for (int k = 0; k < length && words_sent < WORD_TARGET; k++) begin
            idle_input(pick_gap());
            send_word(pick_value(spread), k == 0);
        end
    endtask

    // Watchdog.
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("run did not finish within %0d cycles", CYCLE_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    // Result side: check each word taken and throttle ready, with one long hold-off.
    initial begin
        int  hold;
        int  gap;
        bit  pressure_done;
        hold          = 0;
        pressure_done = 1'b0;
        out_ch.ready  = 1'b0;
        wait (out_of_reset);
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                sb.check_answer(out_ch.found, out_ch.predecessor, out_ch.store_full);
            end
            @(negedge i_clk);
            if (hold > 0) begin
                hold--;
                out_ch.ready = 1'b0;
            end else begin
                if (!pressure_done && sb.checked >= 400) begin
                    pressure_done = 1'b1;
                    gap = HOLD_OFF;
                end else begin
                    gap = pick_gap();
                end
                if (gap > 0) begin
                    hold         = gap - 1;
                    out_ch.ready = 1'b0;
                end else begin
                    out_ch.ready = 1'b1;
                end
            end
        end
    end

    // Reset, directed words, random arrays, drain and verdict.
    initial begin
        int      length;
        int      r;
        t_spread spread;
        sb              = new();
        words_sent      = 0;
        quiet_phase     = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.value     = '0;
        in_ch.start_new = 1'b0;
        i_rst_n         = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n      = 1'b1;
        out_of_reset = 1'b1;

        // Directed: empty store, equal values, both extremes, duplicates and restarts.
        send_word(0, 1'b1);
        send_word(0, 1'b0);
        send_word(VMIN, 1'b0);
        send_word(VMAX, 1'b0);
        send_word(-1, 1'b0);
        send_word(1, 1'b0);
        send_word(VMAX, 1'b0);
        send_word(VMIN, 1'b0);
        send_word(VMIN + 1, 1'b0);
        send_word(VMAX - 1, 1'b0);
        send_word(VMAX, 1'b1);
        send_word(VMAX, 1'b0);
        send_word(VMIN, 1'b0);
        send_word(VMAX, 1'b0);
        send_word(5, 1'b1);
        send_word(3, 1'b0);
        send_word(4, 1'b0);
        send_word(7, 1'b0);
        send_word(4, 1'b0);
        send_word(6, 1'b0);
        send_word(VMIN, 1'b1);

        // The first random array overflows the store.
        send_array(CAPACITY + 14, SPREAD_WIDE);

        // Random arrays: mostly short, some medium, a few past capacity.
        while (words_sent < WORD_TARGET) begin
            quiet_phase = ($urandom_range(0, 4) == 0);
            r           = $urandom_range(0, 99);
            if (r < 80) length = $urandom_range(1, 20);
            else if (r < 95) length = $urandom_range(21, 100);
            else length = $urandom_range(CAPACITY - 2, CAPACITY + 40);
            spread = t_spread'($urandom_range(0, 2));
            send_array(length, spread);
        end
        quiet_phase = 1'b0;
        idle_input(1);

        // Drain, then allow a chain's length for stray results.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (CAPACITY + 50) @(posedge i_clk);

        $display("%0d words in %0d arrays, %0d results checked", words_sent, sb.arrays,
                 sb.checked);
        $display("%0d results had a smaller value, %0d hit a full store", sb.found_hits,
                 sb.full_hits);
        if (sb.fails == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
